@@ sv/pjt_pkg.sv @@
// ----------------------------------------------------------------------------
// pjt_pkg
// Shared constants, codes and controller/datapath interface types for the
// piecewise constant-jerk trajectory evaluator.
// ----------------------------------------------------------------------------
package pjt_pkg;

  localparam int MAX_SEGMENTS  = 16;
  localparam int FRACTION_BITS = 16;
  localparam int SEG_IDX_W     = $clog2(MAX_SEGMENTS);
  localparam int COUNT_W       = $clog2(MAX_SEGMENTS + 1);
  localparam int ENTRY_W       = 160;
  localparam int DIV_STEPS     = 2;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] CFG_START_POS = 2'd0;
  localparam logic [1:0] CFG_START_VEL = 2'd1;
  localparam logic [1:0] CFG_START_ACC = 2'd2;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_EVAL   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ORD_POS  = 2'd0,
    ORD_VEL  = 2'd1,
    ORD_ACC  = 2'd2,
    ORD_JERK = 2'd3
  } order_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_DURATION = 2'd1,
    ST_FULL         = 2'd2,
    ST_EMPTY        = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_APP_LOAD, S_SCAN_RD, S_SCAN_CMP, S_SEG_RD, S_SEG_LOAD,
    S_POLY, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_ADD, S_DIV_INIT, S_DIV_STEP,
    S_FIN, S_RESTART, S_COMMIT, S_CLEAR, S_RESP
  } state_t;

  typedef enum logic [4:0] {
    DP_NONE, DP_LATCH, DP_APP_LOAD, DP_SCAN_RD, DP_SCAN_CMP, DP_SEG_RD,
    DP_SEG_LOAD, DP_MUL0, DP_MUL1, DP_MUL2, DP_MUL3, DP_ADD, DP_DIV_INIT,
    DP_DIV_STEP, DP_FIN, DP_RESTART, DP_COMMIT, DP_CLEAR, DP_RESP
  } dp_op_t;

  typedef struct packed {
    dp_op_t                 op;
    order_t                 order;
    logic [1:0]             step;
    logic [SEG_IDX_W-1:0]   addr;
    status_t                status;
  } ctrl_cmd_t;

  typedef struct packed {
    opcode_t                opcode;
    order_t                 order;
    logic                   tv_nonpos;
    logic                   empty;
    logic                   full;
    logic                   one_seg;
    logic [SEG_IDX_W-1:0]   last_idx;
  } dp_stat_t;

endpackage

@@ sv/pjt_ram.sv @@
// ----------------------------------------------------------------------------
// pjt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pjt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/pjt_ctrl.sv @@
// ----------------------------------------------------------------------------
// pjt_ctrl
// Sequencer: decodes an item, runs the segment scan, the horner steps on the
// shared multiplier, the divide-by-six and the response.
// ----------------------------------------------------------------------------
module pjt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pjt_pkg::dp_stat_t   stat,
  output pjt_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);
  import pjt_pkg::*;

  state_t               state, state_next;
  order_t               order_r, order_next;
  logic [1:0]           k, k_next;
  logic [SEG_IDX_W-1:0] idx, idx_next;
  logic [DIV_CNT_W-1:0] dcnt, dcnt_next;
  status_t              st, st_next;
  logic [1:0]           nsteps;

  // horner steps: three for position, down to none for jerk
  assign nsteps = 2'(2'd3 - order_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      order_r <= ORD_POS;
      k       <= '0;
      idx     <= '0;
      dcnt    <= '0;
      st      <= ST_OK;
    end else begin
      state   <= state_next;
      order_r <= order_next;
      k       <= k_next;
      idx     <= idx_next;
      dcnt    <= dcnt_next;
      st      <= st_next;
    end
  end

  always_comb begin
    state_next = state;
    order_next = order_r;
    k_next     = k;
    idx_next   = idx;
    dcnt_next  = dcnt;
    st_next    = st;
    case (state)
      S_IDLE: begin
        if (start) begin
          st_next    = ST_OK;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.opcode)
          OP_APPEND: begin
            if (stat.tv_nonpos) begin
              st_next    = ST_BAD_DURATION;
              state_next = S_RESP;
            end else if (stat.full) begin
              st_next    = ST_FULL;
              state_next = S_RESP;
            end else begin
              state_next = S_APP_LOAD;
            end
          end
          OP_EVAL: begin
            if (stat.empty) begin
              st_next    = ST_EMPTY;
              state_next = S_RESP;
            end else if (stat.one_seg) begin
              state_next = S_SEG_RD;
            end else begin
              idx_next   = SEG_IDX_W'(1);
              state_next = S_SCAN_RD;
            end
          end
          OP_CLEAR: state_next = S_CLEAR;
          default:  state_next = S_RESP;
        endcase
      end
      S_APP_LOAD: begin
        order_next = ORD_ACC;
        k_next     = '0;
        state_next = S_POLY;
      end
      S_SCAN_RD: state_next = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (idx == stat.last_idx) begin
          state_next = S_SEG_RD;
        end else begin
          idx_next   = idx + SEG_IDX_W'(1);
          state_next = S_SCAN_RD;
        end
      end
      S_SEG_RD: state_next = S_SEG_LOAD;
      S_SEG_LOAD: begin
        order_next = stat.order;
        k_next     = '0;
        state_next = S_POLY;
      end
      S_POLY: begin
        if (k == nsteps) begin
          state_next = (order_r == ORD_POS) ? S_DIV_INIT : S_FIN;
        end else begin
          state_next = S_MUL0;
        end
      end
      S_MUL0: state_next = S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_MUL3;
      S_MUL3: state_next = S_ADD;
      S_ADD: begin
        k_next     = k + 2'd1;
        state_next = S_POLY;
      end
      S_DIV_INIT: begin
        dcnt_next  = '0;
        state_next = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        dcnt_next = dcnt + DIV_CNT_W'(1);
        if (dcnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.opcode == OP_APPEND) begin
          if (order_r == ORD_POS) begin
            state_next = S_COMMIT;
          end else begin
            order_next = order_t'(order_r - 2'd1);
            k_next     = '0;
            state_next = S_RESTART;
          end
        end else begin
          state_next = S_RESP;
        end
      end
      S_RESTART: state_next = S_POLY;
      S_COMMIT:  state_next = S_RESP;
      S_CLEAR:   state_next = S_RESP;
      S_RESP:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op     = DP_NONE;
    cmd.order  = order_r;
    cmd.step   = k;
    cmd.addr   = idx;
    cmd.status = st;
    case (state)
      S_IDLE:     cmd.op = start ? DP_LATCH : DP_NONE;
      S_APP_LOAD: cmd.op = DP_APP_LOAD;
      S_SCAN_RD:  cmd.op = DP_SCAN_RD;
      S_SCAN_CMP: cmd.op = DP_SCAN_CMP;
      S_SEG_RD:   cmd.op = DP_SEG_RD;
      S_SEG_LOAD: cmd.op = DP_SEG_LOAD;
      S_MUL0:     cmd.op = DP_MUL0;
      S_MUL1:     cmd.op = DP_MUL1;
      S_MUL2:     cmd.op = DP_MUL2;
      S_MUL3:     cmd.op = DP_MUL3;
      S_ADD:      cmd.op = DP_ADD;
      S_DIV_INIT: cmd.op = DP_DIV_INIT;
      S_DIV_STEP: cmd.op = DP_DIV_STEP;
      S_FIN:      cmd.op = DP_FIN;
      S_RESTART:  cmd.op = DP_RESTART;
      S_COMMIT:   cmd.op = DP_COMMIT;
      S_CLEAR:    cmd.op = DP_CLEAR;
      S_RESP:     cmd.op = DP_RESP;
      default:    cmd.op = DP_NONE;
    endcase
  end

  assign busy = (state != S_IDLE);

  a_start_decodes: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> state == S_DECODE)
    else $error("accepted item not decoded");

  a_div_bounded: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV_STEP |-> dcnt < DIV_CNT_W'(DIV_STEPS))
    else $error("divide step count overrun");

  a_resp_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_RESP |=> state == S_IDLE)
    else $error("response not followed by idle");

  a_horner_bounded: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL0 |-> k < nsteps)
    else $error("horner step past polynomial degree");

endmodule

@@ sv/pjt_dp.sv @@
// ----------------------------------------------------------------------------
// pjt_dp
// Datapath: segment table, end state, config registers, shared 33x32
// multiplier with round and saturate, horner accumulator, divide-by-six.
// ----------------------------------------------------------------------------
module pjt_dp (
  input  logic                clk,
  input  logic                rst,
  input  pjt_pkg::ctrl_cmd_t  cmd,
  output pjt_pkg::dp_stat_t   stat,
  input  logic [1:0]          opcode,
  input  logic [1:0]          derivative_order,
  input  logic signed [31:0]  jerk_value,
  input  logic signed [31:0]  time_value,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic                done,
  output logic signed [31:0]  result_value,
  output logic [30:0]         total_length,
  output logic [4:0]          segment_count,
  output logic [1:0]          status
);
  import pjt_pkg::*;

  localparam logic [96:0] HALF     = 97'd1 << (FRACTION_BITS - 1);
  localparam logic [64:0] DIV_LIM  = 65'd6 << 31;
  localparam logic [63:0] MAG_POS  = {1'b0, {63{1'b1}}};
  localparam logic [63:0] MAG_NEG  = {1'b1, 63'd0};
  // low word of (2^34 + 2) / 3, the high word is one
  localparam logic [31:0] RECIP_LO = 32'h5555_5556;

  logic signed [31:0] cfg_pos, cfg_vel, cfg_acc;
  logic signed [31:0] end_pos, end_vel, end_acc;
  logic [30:0]        end_time;
  logic [COUNT_W-1:0] count;

  opcode_t            opcode_q;
  order_t             order_q;
  logic signed [31:0] jerk_q, tv_q;

  logic signed [31:0] op_p, op_v, op_a, op_j;
  logic signed [32:0] op_t;
  logic signed [63:0] s, mres;
  logic [64:0]        prod;
  logic [96:0]        acc;
  logic               neg_m;
  logic [32:0]        div_h;
  logic [64:0]        div_p;
  logic [31:0]        div_q;
  logic [65:0]        div_sum;
  logic               div_sat;
  logic signed [31:0] res, nxt_pos, nxt_vel, nxt_acc;
  logic [SEG_IDX_W-1:0] seg, rd_addr_q;

  logic                 ram_we;
  logic [SEG_IDX_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;
  logic signed [31:0]   rd_time;

  logic [32:0]  tmag;
  logic [63:0]  smag;
  logic [32:0]  mul_a;
  logic [31:0]  mul_src;
  logic [64:0]  mul_out;
  logic [96:0]  rnd, shifted;
  logic [63:0]  mag;
  logic signed [63:0] mul_res, coef;
  logic [64:0]  n3, n1;
  logic [31:0]  qm_pos, qm_vel;
  logic signed [31:0] fin;
  logic [31:0]  end_sum;

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] x,
                                                input logic signed [63:0] y);
    logic [64:0] sum;
    sum = {x[63], x} + {y[63], y};
    if (sum[64] != sum[63]) begin
      return sum[64] ? MAG_NEG : MAG_POS;
    end
    return sum[63:0];
  endfunction

  function automatic logic signed [31:0] sat_mag(input logic [31:0] qm,
                                                 input logic neg);
    if (neg) begin
      return 32'(~qm + 32'd1);
    end
    return qm[31] ? 32'h7fff_ffff : qm;
  endfunction

  // coefficient of each horner step: a, then v, then p, scaled to the divisor (3a, 6v, 6p for position)
  function automatic logic signed [63:0] horner_coef(input order_t o,
                                                     input logic [1:0] k,
                                                     input logic signed [31:0] p,
                                                     input logic signed [31:0] v,
                                                     input logic signed [31:0] a);
    logic signed [31:0] x;
    logic signed [63:0] x1, x2, x3;
    x  = (k == 2'd0) ? a : ((k == 2'd1) ? v : p);
    x1 = {{32{x[31]}}, x};
    x2 = x1 <<< 1;
    x3 = x2 + x1;
    case (o)
      ORD_POS: return (k == 2'd0) ? x3 : (x3 <<< 1);
      ORD_VEL: return x2;
      default: return x1;
    endcase
  endfunction

  // {start time, position, velocity, acceleration, jerk}
  assign ram_we    = (cmd.op == DP_APP_LOAD);
  assign ram_wdata = {1'b0, end_time, end_pos, end_vel, end_acc, jerk_q};
  assign ram_raddr = (cmd.op == DP_SEG_RD) ? seg : cmd.addr;
  assign rd_time   = ram_rdata[159:128];

  pjt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_SEGMENTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[SEG_IDX_W-1:0]),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // multiply t * s, round half away from zero, saturate to 64 bits
  assign tmag    = op_t[32] ? 33'(~op_t + 33'd1) : op_t;
  assign smag    = s[63] ? 64'(~s + 64'd1) : s;
  assign mul_a   = (cmd.op == DP_DIV_STEP) ? div_h : tmag;
  always_comb begin
    if (cmd.op == DP_DIV_STEP) begin
      mul_src = RECIP_LO;
    end else if (cmd.op == DP_MUL0) begin
      mul_src = smag[31:0];
    end else begin
      mul_src = smag[63:32];
    end
  end
  assign mul_out = 65'(mul_a) * 65'(mul_src);
  assign rnd     = acc + HALF;
  assign shifted = rnd >> FRACTION_BITS;

  always_comb begin
    mag = (|shifted[96:64]) ? '1 : shifted[63:0];
    if (neg_m) begin
      if (mag > MAG_NEG) mag = MAG_NEG;
      mul_res = 64'(~mag + 64'd1);
    end else begin
      if (mag > MAG_POS) mag = MAG_POS;
      mul_res = mag;
    end
  end

  assign coef = horner_coef(cmd.order, cmd.step, op_p, op_v, op_a);

  assign n3 = {1'b0, smag} + 65'd3;
  assign n1 = {1'b0, smag} + 65'd1;

  // floor(n / 6) as floor(floor(n / 2) * (2^34 + 2) / 3 / 2^34), exact below 2^33
  assign div_sum = 66'({div_h, 32'd0}) + 66'(div_p);

  assign qm_pos = div_sat ? 32'h8000_0000 : div_q;
  assign qm_vel = (|n1[64:32]) ? 32'h8000_0000 : n1[32:1];

  always_comb begin
    case (cmd.order)
      ORD_POS: fin = sat_mag(qm_pos, s[63]);
      ORD_VEL: fin = sat_mag(qm_vel, s[63]);
      ORD_ACC: begin
        if ((&s[63:31]) || !(|s[63:31])) begin
          fin = s[31:0];
        end else begin
          fin = s[63] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
      end
      default: fin = op_j;
    endcase
  end

  assign end_sum = {1'b0, end_time} + {1'b0, tv_q[30:0]};

  always_ff @(posedge clk) begin
    rd_addr_q <= ram_raddr;
    if (rst) begin
      done     <= 1'b0;
      cfg_pos  <= '0;
      cfg_vel  <= '0;
      cfg_acc  <= '0;
      end_pos  <= '0;
      end_vel  <= '0;
      end_acc  <= '0;
      end_time <= '0;
      count    <= '0;
    end else begin
      done <= 1'b0;
      case (cmd.op)
        DP_LATCH: begin
          opcode_q <= opcode_t'(opcode);
          order_q  <= order_t'(derivative_order);
          jerk_q   <= jerk_value;
          tv_q     <= time_value;
          seg      <= '0;
          res      <= '0;
        end
        DP_APP_LOAD: begin
          op_p <= end_pos;
          op_v <= end_vel;
          op_a <= end_acc;
          op_j <= jerk_q;
          op_t <= {tv_q[31], tv_q};
          s    <= {{32{jerk_q[31]}}, jerk_q};
        end
        DP_SCAN_CMP: begin
          if (rd_time < tv_q) seg <= rd_addr_q;
        end
        DP_SEG_LOAD: begin
          op_p <= ram_rdata[127:96];
          op_v <= ram_rdata[95:64];
          op_a <= ram_rdata[63:32];
          op_j <= ram_rdata[31:0];
          op_t <= {tv_q[31], tv_q} - {rd_time[31], rd_time};
          s    <= {{32{ram_rdata[31]}}, ram_rdata[31:0]};
        end
        DP_RESTART: s <= {{32{op_j[31]}}, op_j};
        DP_MUL0: begin
          prod  <= mul_out;
          neg_m <= op_t[32] ^ s[63];
        end
        DP_MUL1: begin
          acc  <= {32'd0, prod};
          prod <= mul_out;
        end
        DP_MUL2: acc <= acc + {prod[64:0], 32'd0};
        DP_MUL3: mres <= mul_res;
        DP_ADD:  s <= sadd64(coef, mres);
        DP_DIV_INIT: begin
          div_sat <= (n3 >= DIV_LIM);
          div_h   <= n3[33:1];
        end
        // first step forms the product, second step the quotient
        DP_DIV_STEP: begin
          div_p <= mul_out;
          div_q <= div_sum[65:34];
        end
        DP_FIN: begin
          if (opcode_q == OP_APPEND) begin
            case (cmd.order)
              ORD_POS: nxt_pos <= fin;
              ORD_VEL: nxt_vel <= fin;
              default: nxt_acc <= fin;
            endcase
          end else begin
            res <= fin;
          end
        end
        DP_COMMIT: begin
          end_pos  <= nxt_pos;
          end_vel  <= nxt_vel;
          end_acc  <= nxt_acc;
          end_time <= end_sum[31] ? '1 : end_sum[30:0];
          count    <= count + COUNT_W'(1);
        end
        DP_CLEAR: begin
          end_pos  <= cfg_pos;
          end_vel  <= cfg_vel;
          end_acc  <= cfg_acc;
          end_time <= '0;
          count    <= '0;
        end
        DP_RESP: begin
          done          <= 1'b1;
          result_value  <= res;
          total_length  <= end_time;
          segment_count <= count;
          status        <= cmd.status;
        end
        default: ;
      endcase
      // empty table: start registers also load the end state
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_POS: begin
            cfg_pos <= cfg_data;
            if (count == '0) end_pos <= cfg_data;
          end
          CFG_START_VEL: begin
            cfg_vel <= cfg_data;
            if (count == '0) end_vel <= cfg_data;
          end
          CFG_START_ACC: begin
            cfg_acc <= cfg_data;
            if (count == '0) end_acc <= cfg_data;
          end
          default: ;
        endcase
      end
    end
  end

  assign stat.opcode    = opcode_q;
  assign stat.order     = order_q;
  assign stat.tv_nonpos = (tv_q <= 32'sd0);
  assign stat.empty     = (count == '0);
  assign stat.full      = (count >= COUNT_W'(MAX_SEGMENTS));
  assign stat.one_seg   = (count == COUNT_W'(1));
  assign stat.last_idx  = SEG_IDX_W'(count - COUNT_W'(1));

endmodule

@@ sv/piecewise_jerk_trajectory_eval_unit.sv @@
// ----------------------------------------------------------------------------
// piecewise_jerk_trajectory_eval_unit
// Constant-jerk segment table with append, evaluate and clear items.
// ----------------------------------------------------------------------------
// One item at a time: start is taken while busy is low, and one result per
// item comes back as a single-cycle done strobe that cannot be held off.
// The time of an item is set by the linear scan of the start times on an
// evaluate (one entry after another through the table's registered read
// port), the shared 33x32 multiplier that runs each horner step, with fewer
// steps for a higher derivative order, and the divide by six on the position
// path, a reciprocal product on the same multiplier. Config writes are always
// ready and are to be made while the block is idle.
// ----------------------------------------------------------------------------
module piecewise_jerk_trajectory_eval_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic [1:0]         derivative_order,
  input  logic signed [31:0] jerk_value,
  input  logic signed [31:0] time_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] result_value,
  output logic [30:0]        total_length,
  output logic [4:0]         segment_count,
  output logic [1:0]         status
);
  import pjt_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  pjt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  pjt_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .opcode          (opcode),
    .derivative_order(derivative_order),
    .jerk_value      (jerk_value),
    .time_value      (time_value),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .result_value    (result_value),
    .total_length    (total_length),
    .segment_count   (segment_count),
    .status          (status)
  );

endmodule
